// ===== hw/rtl/ula_pkg.sv =====
// Shared types and constants of the UART line assembler.
`default_nettype none

package ula_pkg;

    localparam int NUM_LINES_DEF  = 4;
    localparam int LINE_CHARS_DEF = 32;

    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int TIME_W    = 32;
    localparam int BACK_W    = 2;
    localparam int INDEX_W   = 5;
    localparam int LEN_OUT_W = 6;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [APB_ADDR_W-1:0] ADDR_FULL_LINE_MODE = 3'd0;
    localparam logic                  FULL_LINE_MODE_RST  = 1'b1;

    localparam logic [BYTE_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CHR_TILDE = 8'h7E;
    localparam logic [BYTE_W-1:0] CHR_CR    = 8'h0D;
    localparam logic [BYTE_W-1:0] CHR_LF    = 8'h0A;

    typedef enum logic [CMD_W-1:0] {
        CMD_RX   = 2'd0,
        CMD_READ = 2'd1,
        CMD_POLL = 2'd2
    } t_cmd;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [BYTE_W-1:0]  rx_byte;
        logic [TIME_W-1:0]  now_ms;
        logic [BACK_W-1:0]  lines_back;
        logic [INDEX_W-1:0] char_index;
    } t_req;

    typedef struct packed {
        logic                 byte_stored;
        logic [BYTE_W-1:0]    read_char;
        logic [LEN_OUT_W-1:0] line_length;
        logic [TIME_W-1:0]    line_time;
        logic                 buffer_empty;
        logic                 new_data;
    } t_rsp;

endpackage

`default_nettype wire

// ===== hw/rtl/ula_stream_if.sv =====
// Valid/ready stream interface that carries one request or one result.
`default_nettype none

interface ula_stream_if #(
    parameter type T = logic
) ();

    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== hw/rtl/uart_line_assembler_top.sv =====
// Top level of the UART line assembler: line ring, character memory and result stage.
//
// Requests arrive on i_req (valid/ready): cmd 0 hands over a received byte, cmd 1
// reads one character of a line counted back from the newest one, and cmd 2 polls
// and clears the new-data flag. Every request gives exactly one result on o_rsp.
// The only register, full_line_mode, sits on the APB port at byte address 0;
// pready is always high and writes are expected while the block is idle.
// A request is taken into an input register and processed there against the line
// state and the character memory; its result is then loaded into the output
// register, which drives o_rsp.valid. Throughput is one request per cycle while
// the receiver does not stall; the memory's registered read port sets the
// two-stage depth. When the receiver stalls, the result register holds and the
// input register still takes one more request before i_req.ready drops.
// Synchronous reset empties both stages, clears all line lengths and timestamps,
// the write position and the flags, and sets full_line_mode to 1. The character
// memory is not cleared; characters at or past a line's length read as zero.
`default_nettype none

module uart_line_assembler_top
    import ula_pkg::*;
#(
    parameter int NUM_LINES  = NUM_LINES_DEF,
    parameter int LINE_CHARS = LINE_CHARS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    ula_stream_if.sink                 i_req,
    ula_stream_if.source               o_rsp
);

    localparam int LINE_W = $clog2(NUM_LINES);
    localparam int POS_W  = $clog2(LINE_CHARS + 1);
    localparam int DEPTH  = NUM_LINES * LINE_CHARS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int BACK_STEPS = (1 << BACK_W) - 1;

    function automatic logic [LINE_W-1:0] line_inc(input logic [LINE_W-1:0] l);
        return (l == LINE_W'(NUM_LINES - 1)) ? '0 : l + 1'b1;
    endfunction

    function automatic logic [LINE_W-1:0] line_dec(input logic [LINE_W-1:0] l);
        return (l == '0) ? LINE_W'(NUM_LINES - 1) : l - 1'b1;
    endfunction

    logic                r_mode;
    logic [LINE_W-1:0]   r_active;
    logic [POS_W-1:0]    r_wpos;
    logic                r_last_eol;
    logic                r_fresh;
    logic                r_any;
    logic [POS_W-1:0]    r_len   [NUM_LINES];
    logic [TIME_W-1:0]   r_stamp [NUM_LINES];
    logic [BYTE_W-1:0]   mem     [DEPTH];

    logic                r_a_valid;
    t_req                r_a;
    logic                r_b_valid;
    t_rsp                r_rsp;
    logic                r_char_ok;
    logic [BYTE_W-1:0]   r_rd_data;

    logic                w_adv;
    logic                w_eol;
    logic                w_printable;
    logic                w_store;
    logic [LINE_W-1:0]   w_line;
    logic [POS_W-1:0]    w_pos;
    logic [LINE_W-1:0]   w_line1;
    logic [POS_W-1:0]    w_pos1;
    logic [LINE_W-1:0]   w_sel;
    logic                w_is_read;
    logic                w_char_ok;
    logic                w_nd;
    logic [ADDR_W-1:0]   w_waddr;
    logic [ADDR_W-1:0]   w_raddr;
    logic [LINE_W-1:0]   n_active;
    logic [POS_W-1:0]    n_wpos;
    logic                n_last_eol;
    logic                n_fresh;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FULL_LINE_MODE) ? APB_DATA_W'(r_mode) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= FULL_LINE_MODE_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_FULL_LINE_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    assign w_adv       = r_a_valid && (!r_b_valid || o_rsp.ready);
    assign i_req.ready = !r_a_valid || w_adv;

    always_comb begin
        w_eol       = (r_a.rx_byte == CHR_CR) || (r_a.rx_byte == CHR_LF);
        w_printable = (r_a.rx_byte >= CHR_SPACE) && (r_a.rx_byte <= CHR_TILDE);
        w_line1     = (w_eol && !r_last_eol) ? line_inc(r_active) : r_active;
        w_pos1      = (w_eol && !r_last_eol) ? '0 : r_wpos;
        w_store     = 1'b0;
        w_line      = w_line1;
        w_pos       = w_pos1;
        n_active    = r_active;
        n_wpos      = r_wpos;
        n_last_eol  = r_last_eol;
        n_fresh     = r_fresh;
        case (r_a.cmd)
            CMD_RX: begin
                if (w_printable || w_eol) begin
                    n_last_eol = w_eol;
                    n_active   = w_line1;
                    n_wpos     = w_pos1;
                    if (!(w_pos1 == '0 && w_eol)) begin
                        if (w_pos1 >= POS_W'(LINE_CHARS)) begin
                            if (r_mode) begin
                                w_store = 1'b1;
                                w_line  = line_inc(w_line1);
                                w_pos   = '0;
                            end
                        end else begin
                            w_store = 1'b1;
                        end
                    end
                    if (w_store) begin
                        n_active = w_line;
                        n_wpos   = w_pos + 1'b1;
                        n_fresh  = 1'b1;
                    end
                end
            end
            CMD_POLL: begin
                n_fresh = 1'b0;
            end
            default: begin
            end
        endcase
        w_nd = (r_a.cmd == CMD_POLL) ? r_fresh : n_fresh;
    end

    always_comb begin
        w_sel = r_active;
        for (int k = 0; k < BACK_STEPS; k++) begin
            if (k < int'(r_a.lines_back)) begin
                w_sel = line_dec(w_sel);
            end
        end
        if (r_last_eol) begin
            w_sel = line_dec(w_sel);
        end
        w_is_read = (r_a.cmd == CMD_READ);
        w_char_ok = w_is_read && (int'(r_a.char_index) < int'(r_len[w_sel]));
        w_raddr   = ADDR_W'(int'(w_sel) * LINE_CHARS + int'(r_a.char_index));
        w_waddr   = ADDR_W'(int'(w_line) * LINE_CHARS + int'(w_pos));
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_store) begin
            mem[w_waddr] <= r_a.rx_byte;
        end
        if (w_adv) begin
            r_rd_data <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_wpos     <= '0;
            r_last_eol <= 1'b0;
            r_fresh    <= 1'b0;
            r_any      <= 1'b0;
            for (int i = 0; i < NUM_LINES; i++) begin
                r_len[i]   <= '0;
                r_stamp[i] <= '0;
            end
        end else if (w_adv) begin
            r_active   <= n_active;
            r_wpos     <= n_wpos;
            r_last_eol <= n_last_eol;
            r_fresh    <= n_fresh;
            if (w_store) begin
                r_any           <= 1'b1;
                r_len[w_line]   <= w_pos + 1'b1;
                r_stamp[w_line] <= r_a.now_ms;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_a_valid <= i_req.valid;
            end
            if (w_adv) begin
                r_b_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_a <= i_req.payload;
        end
        if (w_adv) begin
            r_char_ok            <= w_char_ok;
            r_rsp.byte_stored    <= w_store;
            r_rsp.read_char      <= '0;
            r_rsp.line_length    <= w_is_read ? LEN_OUT_W'(r_len[w_sel]) : '0;
            r_rsp.line_time      <= w_is_read ? r_stamp[w_sel] : '0;
            r_rsp.buffer_empty   <= !(r_any || w_store);
            r_rsp.new_data       <= w_nd;
        end
    end

    always_comb begin
        o_rsp.valid             = r_b_valid;
        o_rsp.payload           = r_rsp;
        o_rsp.payload.read_char = r_char_ok ? r_rd_data : '0;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ula_checker.sv =====
// Port-level checker of the UART line assembler and its bind to the top level.
`default_nettype none

module ula_checker
    import ula_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_valid,
    input wire logic i_ready,
    input wire t_rsp i_payload
);

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_payload))
        else $error("stalled result changed");

    a_stored_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_payload.byte_stored |-> !i_payload.buffer_empty && i_payload.new_data)
        else $error("stored byte without new data or with empty buffer");

    a_char_needs_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_payload.read_char != '0 |-> !i_payload.buffer_empty)
        else $error("character read from an empty buffer");

endmodule

bind uart_line_assembler_top ula_checker u_ula_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_rsp.valid),
    .i_ready   (o_rsp.ready),
    .i_payload (o_rsp.payload)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench of the UART line assembler with its own line-ring predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ula_pkg::*;

    localparam int NUM_LINES  = NUM_LINES_DEF;
    localparam int LINE_CHARS = LINE_CHARS_DEF;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 60;
    localparam int MAX_SHOWN   = 10;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ula_stream_if #(.T(t_req)) req_if ();
    ula_stream_if #(.T(t_rsp)) rsp_if ();

    uart_line_assembler_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Predicted state of the line ring.
    bit                line_mode;
    int                cur_line;
    int                wr_pos;
    bit                prev_eol;
    bit                fresh;
    logic [BYTE_W-1:0] char_mem [NUM_LINES*LINE_CHARS];
    int                len_of [NUM_LINES];
    logic [TIME_W-1:0] stamp_of [NUM_LINES];
    t_rsp              rsp_due_q [$];

    int n_req;
    int n_rsp;
    int n_stored;
    int n_err;
    int quiet;
    bit gaps_on;
    bit stalls_on;
    bit hold_req;
    int stall_left;

    function automatic void reset_model();
        line_mode = FULL_LINE_MODE_RST;
        cur_line  = 0;
        wr_pos    = 0;
        prev_eol  = 1'b0;
        fresh     = 1'b0;
        foreach (len_of[i]) begin
            len_of[i]   = 0;
            stamp_of[i] = '0;
        end
    endfunction

    function automatic void advance_line();
        cur_line = (cur_line + 1) % NUM_LINES;
        wr_pos   = 0;
    endfunction

    function automatic bit store_byte(logic [BYTE_W-1:0] c, logic [TIME_W-1:0] now);
        bit eol;
        eol = (c == CHR_CR) || (c == CHR_LF);
        if (!((c >= CHR_SPACE && c <= CHR_TILDE) || eol))
            return 1'b0;
        if (eol && !prev_eol)
            advance_line();
        prev_eol = eol;
        if (wr_pos == 0 && eol)
            return 1'b0;
        if (wr_pos >= LINE_CHARS) begin
            if (!line_mode)
                return 1'b0;
            advance_line();
        end
        char_mem[cur_line*LINE_CHARS + wr_pos] = c;
        stamp_of[cur_line] = now;
        wr_pos++;
        len_of[cur_line] = wr_pos;
        fresh = 1'b1;
        return 1'b1;
    endfunction

    function automatic t_rsp assemble_step(t_req r);
        t_rsp o;
        int   sel;
        int   e;
        o = '0;
        case (r.cmd)
            CMD_RX: begin
                o.byte_stored = store_byte(r.rx_byte, r.now_ms);
            end
            CMD_READ: begin
                e   = prev_eol ? 1 : 0;
                sel = (cur_line + 4*NUM_LINES - int'(r.lines_back) - e) % NUM_LINES;
                o.read_char   = (int'(r.char_index) < len_of[sel]) ?
                                char_mem[sel*LINE_CHARS + int'(r.char_index)] : '0;
                o.line_length = len_of[sel][LEN_OUT_W-1:0];
                o.line_time   = stamp_of[sel];
            end
            default: begin
            end
        endcase
        o.new_data = fresh;
        if (r.cmd == CMD_POLL)
            fresh = 1'b0;
        o.buffer_empty = 1'b1;
        foreach (len_of[i])
            if (len_of[i] != 0)
                o.buffer_empty = 1'b0;
        return o;
    endfunction

    function automatic t_req make_req(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] b,
                                      logic [TIME_W-1:0] now, logic [BACK_W-1:0] back,
                                      logic [INDEX_W-1:0] idx);
        t_req r;
        r.cmd        = cmd;
        r.rx_byte    = b;
        r.now_ms     = now;
        r.lines_back = back;
        r.char_index = idx;
        return r;
    endfunction

    function automatic t_req rand_req(logic [CMD_W-1:0] cmd);
        t_req r;
        r.cmd        = cmd;
        r.rx_byte    = BYTE_W'($urandom);
        r.now_ms     = $urandom;
        r.lines_back = BACK_W'($urandom);
        r.char_index = INDEX_W'($urandom_range(0, 1) ? $urandom : $urandom_range(0, 7));
        return r;
    endfunction

    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        do
            b = BYTE_W'($urandom_range(0, 255));
        while ((b >= CHR_SPACE && b <= CHR_TILDE) || b == CHR_CR || b == CHR_LF);
        return b;
    endfunction

    task automatic send_request(input t_req r);
        int   gap;
        t_rsp p;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.payload <= r;
        do
            @(posedge i_clk);
        while (!req_if.ready);
        p = assemble_step(r);
        rsp_due_q.push_back(p);
        n_req++;
        if (p.byte_stored)
            n_stored++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input logic [BYTE_W-1:0] b);
        t_req r;
        r = rand_req(CMD_RX);
        r.rx_byte = b;
        send_request(r);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (rsp_due_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        if (addr == ADDR_FULL_LINE_MODE)
            line_mode = data[0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_line_mode(input bit mode);
        drain_results();
        write_reg(ADDR_FULL_LINE_MODE, {{(APB_DATA_W-1){1'b0}}, mode});
    endtask

    // Mostly well-formed lines of random text, with reads, polls and noise mixed in.
    task automatic run_traffic(input int n_items);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < n_items) begin
            gaps_on   = ($urandom_range(0, 5) != 0);
            stalls_on = ($urandom_range(0, 5) != 0);
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(LINE_CHARS-4, LINE_CHARS+8)
                                              : $urandom_range(0, 12);
            for (int k = 0; k < len; k++) begin
                send_text(BYTE_W'($urandom_range(CHR_SPACE, CHR_TILDE)));
                sent++;
                pick = $urandom_range(0, 19);
                if (pick == 0) begin
                    send_text(noise_byte());
                end else if (pick == 1) begin
                    send_request(rand_req(CMD_POLL));
                    sent++;
                end else if (pick <= 3) begin
                    send_request(rand_req(CMD_READ));
                    sent++;
                end else if (pick == 4 && $urandom_range(0, 3) == 0) begin
                    send_request(rand_req(CMD_UNUSED));
                    sent++;
                end
            end
            pick = $urandom_range(0, 5);
            case (pick)
                0: send_text(CHR_CR);
                1: send_text(CHR_LF);
                2: begin
                    send_text(CHR_CR);
                    send_text(CHR_LF);
                end
                3: begin
                    send_text(CHR_LF);
                    send_text(CHR_CR);
                end
                4: begin
                    send_text(CHR_CR);
                    send_text(CHR_CR);
                    send_text(CHR_LF);
                end
                default: begin
                end
            endcase
            sent += (pick == 5) ? 0 : 1;
            repeat ($urandom_range(1, 3)) begin
                send_request(rand_req(CMD_READ));
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_request(rand_req(CMD_POLL));
                sent++;
            end
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    task automatic test_directed();
        send_request(make_req(CMD_POLL, 8'h00, 32'h0, 2'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd0, 5'd0));
        send_request(make_req(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 2'd3, 5'd31));
        send_request(make_req(CMD_RX, 8'h00, 32'h1, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, CHR_SPACE - 8'd1, 32'h2, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, CHR_TILDE + 8'd1, 32'h3, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, 8'hFF, 32'h4, 2'd3, 5'd31));
        send_request(make_req(CMD_RX, CHR_CR, 32'h5, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, CHR_LF, 32'h6, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, CHR_SPACE, 32'h0, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, CHR_TILDE, 32'hFFFF_FFFF, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, 8'h80, 32'h7, 2'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd0, 5'd1));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd0, 5'd2));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd1, 5'd31));
        send_request(make_req(CMD_RX, CHR_LF, 32'h8, 2'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd0, 5'd1));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd3, 5'd31));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd2, 5'd0));
        send_request(make_req(CMD_POLL, 8'h00, 32'h0, 2'd0, 5'd0));
        send_request(make_req(CMD_POLL, 8'h00, 32'h0, 2'd0, 5'd0));
        send_request(make_req(CMD_UNUSED, 8'h00, 32'h0, 2'd0, 5'd0));
        send_request(make_req(CMD_RX, CHR_CR, 32'h9, 2'd0, 5'd0));
        send_request(make_req(CMD_READ, 8'h00, 32'h0, 2'd0, 5'd0));
    endtask

    task automatic test_drop_when_full();
        set_line_mode(1'b0);
        run_traffic(200);
    endtask

    task automatic test_wrap_when_full();
        set_line_mode(1'b1);
        run_traffic(250);
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        repeat (40) begin
            if ($urandom_range(0, 3) == 0)
                send_request(rand_req(CMD_READ));
            else
                send_text(BYTE_W'($urandom_range(CHR_SPACE, CHR_TILDE)));
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_mixed_modes();
        set_line_mode(1'b0);
        run_traffic(150);
        set_line_mode(1'b1);
        run_traffic(150);
    endtask

    task automatic note_mismatch(input string what, input logic [TIME_W-1:0] want,
                                 input logic [TIME_W-1:0] got);
        n_err++;
        if (n_err <= MAX_SHOWN)
            $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
    endtask

    // Result checker: each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            n_rsp++;
            stall_left = stalls_on ? $urandom_range(0, 3) : 0;
            got = rsp_if.payload;
            if (rsp_due_q.size() == 0) begin
                note_mismatch("result with no request waiting", '0, got.line_time);
            end else begin
                want = rsp_due_q.pop_front();
                if (got.byte_stored !== want.byte_stored)
                    note_mismatch("byte_stored", TIME_W'(want.byte_stored),
                                  TIME_W'(got.byte_stored));
                if (got.read_char !== want.read_char)
                    note_mismatch("read_char", TIME_W'(want.read_char),
                                  TIME_W'(got.read_char));
                if (got.line_length !== want.line_length)
                    note_mismatch("line_length", TIME_W'(want.line_length),
                                  TIME_W'(got.line_length));
                if (got.line_time !== want.line_time)
                    note_mismatch("line_time", want.line_time, got.line_time);
                if (got.buffer_empty !== want.buffer_empty)
                    note_mismatch("buffer_empty", TIME_W'(want.buffer_empty),
                                  TIME_W'(got.buffer_empty));
                if (got.new_data !== want.new_data)
                    note_mismatch("new_data", TIME_W'(want.new_data),
                                  TIME_W'(got.new_data));
            end
        end
    end

    // Result receiver with random stalls and an occasional long hold.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            rsp_if.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= IDLE_LIMIT) begin
                $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_if.valid   = 1'b0;
        req_if.payload = '0;
        n_req          = 0;
        n_rsp          = 0;
        n_stored       = 0;
        n_err          = 0;
        quiet          = 0;
        gaps_on        = 1'b1;
        stalls_on      = 1'b1;
        hold_req       = 1'b0;
        stall_left     = 0;
        reset_model();
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_drop_when_full();
        test_wrap_when_full();
        test_backpressure();
        test_mixed_modes();
        drain_results();

        while (rsp_due_q.size() != 0) begin
            void'(rsp_due_q.pop_front());
            note_mismatch("missing result", '1, '0);
        end
        $display("Run covered %0d requests and %0d results, %0d bytes stored in the ring,",
                 n_req, n_rsp, n_stored);
        $display("both full-line modes, CR/LF rules, noise bytes and a %0d-cycle receiver hold.",
                 HOLD_CYCLES);
        if (n_err == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
